// ===== hw/rtl/text_encoding_detector_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef TEXT_ENCODING_DETECTOR_UNIT_MACROS_SVH
`define TEXT_ENCODING_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define TED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ted_pkg.sv =====
// types and constants of the text encoding detector
`default_nettype none

package ted_pkg;

    // byte count limit and counter width
    localparam int unsigned MAX_BYTES = 16777216;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int unsigned HEAD_W    = 24;

    typedef logic [CNT_W-1:0] cnt_t;

    // byte order marks
    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FF = 8'hFF;
    localparam logic [7:0] BOM16_FE = 8'hFE;

    // lead byte codes
    localparam logic [7:0] ASCII_END = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;

    // continuation byte bounds
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;

    // bound on the first continuation byte
    typedef enum logic [2:0] {
        RULE_ANY = 3'd0,
        RULE_E0  = 3'd1,
        RULE_ED  = 3'd2,
        RULE_F0  = 3'd3,
        RULE_F4  = 3'd4
    } rule_t;

    // result classes
    typedef enum logic [2:0] {
        CLS_UTF8     = 3'd0,
        CLS_UTF8_BOM = 3'd1,
        CLS_UTF16LE  = 3'd2,
        CLS_UTF16BE  = 3'd3,
        CLS_LOCAL    = 3'd4
    } cls_t;

    // per-item control to the state units
    typedef struct packed {
        logic take;   // item carries a byte and is processed now
        logic clear;  // item ends the file, state returns to reset
    } ctl_t;

    // statistics after the current item
    typedef struct packed {
        cnt_t              byte_total;
        cnt_t              nul_total;
        cnt_t              nul_odd_total;
        logic [HEAD_W-1:0] head;
        logic              overflow;
    } stats_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ted_utf8.sv =====
// strict utf-8 validator state and next-state logic
`default_nettype none

module ted_utf8
    import ted_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctl_t       ctl,
    input  wire logic [7:0] byte_value,
    output logic            utf8_ok
);

    logic [1:0] pend_reg, pend_next;
    rule_t      rule_reg, rule_next;
    logic       ok_reg, ok_next;
    logic [7:0] lo;
    logic [7:0] hi;

    always_comb begin
        pend_next = pend_reg;
        rule_next = rule_reg;
        ok_next   = ok_reg;
        lo        = CONT_LO;
        hi        = CONT_HI;
        case (rule_reg)
            RULE_E0: lo = E0_LO;
            RULE_ED: hi = ED_HI;
            RULE_F0: lo = F0_LO;
            RULE_F4: hi = F4_HI;
            default: ;
        endcase
        if (ctl.take && ok_reg) begin
            if (pend_reg != 2'd0) begin
                if (byte_value < lo || byte_value > hi) begin
                    ok_next = 1'b0;
                end else begin
                    rule_next = RULE_ANY;
                    pend_next = pend_reg - 2'd1;
                end
            end else begin
                rule_next = RULE_ANY;
                if (byte_value < ASCII_END) begin
                    pend_next = 2'd0;
                end else if (byte_value >= LEAD2_LO && byte_value <= LEAD2_HI) begin
                    pend_next = 2'd1;
                end else if (byte_value == LEAD_E0) begin
                    pend_next = 2'd2;
                    rule_next = RULE_E0;
                end else if (byte_value == LEAD_ED) begin
                    pend_next = 2'd2;
                    rule_next = RULE_ED;
                end else if (byte_value > LEAD_E0 && byte_value <= LEAD3_HI) begin
                    pend_next = 2'd2;
                end else if (byte_value == LEAD_F0) begin
                    pend_next = 2'd3;
                    rule_next = RULE_F0;
                end else if (byte_value == LEAD_F4) begin
                    pend_next = 2'd3;
                    rule_next = RULE_F4;
                end else if (byte_value > LEAD_F0 && byte_value < LEAD_F4) begin
                    pend_next = 2'd3;
                end else begin
                    ok_next = 1'b0;
                end
            end
        end
    end

    // truncated sequences count as invalid
    assign utf8_ok = ok_next && (pend_next == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            pend_reg <= 2'd0;
            rule_reg <= RULE_ANY;
            ok_reg   <= 1'b1;
        end else begin
            pend_reg <= pend_next;
            rule_reg <= rule_next;
            ok_reg   <= ok_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ted_stats.sv =====
// byte and nul counters with the three head bytes
`default_nettype none

module ted_stats
    import ted_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctl_t       ctl,
    input  wire logic [7:0] byte_value,
    output stats_t          stats
);

    stats_t st_reg, st_next;

    always_comb begin
        st_next = st_reg;
        if (ctl.take) begin
            if (st_reg.byte_total == CNT_W'(MAX_BYTES)) begin
                st_next.overflow = 1'b1;
            end else begin
                case (st_reg.byte_total)
                    CNT_W'(0): st_next.head[7:0]   = byte_value;
                    CNT_W'(1): st_next.head[15:8]  = byte_value;
                    CNT_W'(2): st_next.head[23:16] = byte_value;
                    default:   ;
                endcase
                if (byte_value == 8'h00) begin
                    st_next.nul_total = st_reg.nul_total + CNT_W'(1);
                    if (st_reg.byte_total[0]) begin
                        st_next.nul_odd_total = st_reg.nul_odd_total + CNT_W'(1);
                    end
                end
                st_next.byte_total = st_reg.byte_total + CNT_W'(1);
            end
        end
    end

    assign stats = st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/text_encoding_detector_unit.sv =====
// top level of the text encoding detector
`default_nettype none

// Classifies a file streamed in one byte per transaction as utf-8, utf-8
// with bom, utf-16le, utf-16be or local 8-bit, and reports strict utf-8
// validity and byte count saturation. A new input transaction can be taken
// every clock cycle while no file end waits for the result slot. A
// transaction with tlast set yields exactly one result transaction, held
// in the input register and then in the result register; earlier
// transactions yield none. While a result waits for m_tready, a file end
// waits in the input register and s_tready stays low until the result slot
// frees. The rate holds because the running counters and the validator
// state update combinationally between the input register and the result
// register. s_tuser marks whether s_tdata carries a byte; a transaction with
// s_tuser low and s_tlast high reports the bytes seen so far (an empty file
// is utf-8). Counters stop at 16777216 bytes; a byte arriving after that
// raises the overflow bit and still goes through the validator.
// Reset is synchronous and active low; after each result the validator and
// counter state returns to its reset value for the next file.

module text_encoding_detector_unit
    import ted_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_value
    input  wire logic       s_tuser,   // [0] has_byte
    input  wire logic       s_tlast,
    // result channel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [2:0] encoding_class, [3] utf8_valid,
                                       // [4] length_overflow, [7:5] zero
);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_has_reg;
    logic       in_last_reg;

    // result register
    logic       out_vld_reg;
    cls_t       out_cls_reg;
    logic       out_valid_reg;
    logic       out_ovf_reg;

    logic       out_free;
    logic       adv;
    ctl_t       ctl;
    stats_t     stats;
    logic       utf8_ok;
    cls_t       cls;
    logic       nul_heavy;
    logic       nul_odd_half;

    // result slot can take a new result this cycle
    assign out_free = !out_vld_reg || m_tready;

    // items without tlast never wait on the result side
    assign adv      = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || adv;

    assign ctl.take  = adv && in_has_reg;
    assign ctl.clear = adv && in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    ted_utf8 u_utf8 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .byte_value (in_byte_reg),
        .utf8_ok    (utf8_ok)
    );

    ted_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .byte_value (in_byte_reg),
        .stats      (stats)
    );

    // more than a quarter of the bytes are nul
    assign nul_heavy = (stats.nul_total != '0) &&
                       ({stats.nul_total, 2'b00} > {2'b00, stats.byte_total});

    // at least half of the nul bytes sit at odd positions
    assign nul_odd_half = {stats.nul_odd_total, 1'b0} >= {1'b0, stats.nul_total};

    // class priority: boms first, then empty file, nul share, validity
    always_comb begin
        if (stats.byte_total >= CNT_W'(3) && stats.head[7:0] == BOM8_B0 &&
            stats.head[15:8] == BOM8_B1 && stats.head[23:16] == BOM8_B2) begin
            cls = CLS_UTF8_BOM;
        end else if (stats.byte_total >= CNT_W'(2) && stats.head[7:0] == BOM16_FF &&
                     stats.head[15:8] == BOM16_FE) begin
            cls = CLS_UTF16LE;
        end else if (stats.byte_total >= CNT_W'(2) && stats.head[7:0] == BOM16_FE &&
                     stats.head[15:8] == BOM16_FF) begin
            cls = CLS_UTF16BE;
        end else if (stats.byte_total == '0) begin
            cls = CLS_UTF8;
        end else if (nul_heavy) begin
            cls = nul_odd_half ? CLS_UTF16LE : CLS_UTF16BE;
        end else if (utf8_ok) begin
            cls = CLS_UTF8;
        end else begin
            cls = CLS_LOCAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ctl.clear) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            out_cls_reg   <= cls;
            out_valid_reg <= utf8_ok;
            out_ovf_reg   <= stats.overflow;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_ovf_reg, out_valid_reg, out_cls_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/ted_checker.sv =====
// port-level checker for the text encoding detector, bound to the top level
`default_nettype none
`include "text_encoding_detector_unit_macros.svh"

module ted_checker
    import ted_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    logic       in_txn;
    logic       out_stall;
    logic [2:0] out_cls;
    logic       pad_zero;

    assign in_txn    = s_tvalid && s_tready && s_tlast;
    assign out_stall = m_tvalid && !m_tready;
    assign out_cls   = m_tdata[2:0];
    assign pad_zero  = (m_tdata[7:5] == 3'b000);

    // a stalled result holds
    `TED_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "result moved")

    // class code in range, pad bits zero
    `TED_ASSERT_NOW(a_out_format, m_tvalid, out_cls <= CLS_LOCAL && pad_zero, "bad format")

    // plain utf-8 class is only given to valid streams
    `TED_ASSERT_NOW(a_utf8_valid, m_tvalid && out_cls == CLS_UTF8, m_tdata[3], "utf-8 not valid")

    // a fresh result needs a file end accepted earlier
    `TED_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(in_txn, 2), "result without a file end")

endmodule

bind text_encoding_detector_unit ted_checker u_ted_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
